@@ rtl/core/planar_link_constraint_jacobian_unit_assert.svh @@
`ifndef PLANAR_LINK_CONSTRAINT_JACOBIAN_UNIT_ASSERT_SVH
`define PLANAR_LINK_CONSTRAINT_JACOBIAN_UNIT_ASSERT_SVH
// implication check on a clock with synchronous reset
`define PLCJ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication check
`define PLCJ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/core/plcj_pkg.sv @@
`default_nettype none
package plcj_pkg;
    localparam int BODY_INDEX_BITS = 8;
    localparam int CORDIC_STAGES   = 16;
    localparam int CORDIC_MAX      = 24;
    localparam int TRIG_W          = 33;
    localparam int PIPE_DEPTH      = CORDIC_STAGES + 7;
    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 33'sd652032874;

    localparam logic [2:0] REG_FIRST_INDEX  = 3'd0;
    localparam logic [2:0] REG_SECOND_INDEX = 3'd1;
    localparam logic [2:0] REG_FIRST_AX     = 3'd2;
    localparam logic [2:0] REG_FIRST_AY     = 3'd3;
    localparam logic [2:0] REG_SECOND_AX    = 3'd4;
    localparam logic [2:0] REG_SECOND_AY    = 3'd5;
    localparam logic [2:0] REG_STIFFNESS    = 3'd6;
    localparam logic [2:0] REG_DAMPING      = 3'd7;

    typedef struct packed {
        logic [7:0]         body_index;
        logic signed [31:0] own_x;
        logic signed [31:0] own_y;
        logic [15:0]        own_angle;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic [15:0]        other_angle;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         constraint_count;
        logic               linear_sign;
        logic signed [31:0] jac_x_angle;
        logic signed [31:0] jac_y_angle;
        logic signed [31:0] curv_x_angle;
        logic signed [31:0] curv_y_angle;
        logic signed [31:0] spring_x;
        logic signed [31:0] spring_y;
        logic [31:0]        damping_out;
    } t_out_item;

    // per-item control that rides along the pipe
    typedef struct packed {
        logic               hit;
        logic               second;
        logic signed [31:0] oax;
        logic signed [31:0] oay;
        logic signed [31:0] lax;
        logic signed [31:0] lay;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [31:0]        stiff;
        logic [31:0]        damp;
    } t_ctl;

    function automatic logic signed [31:0] atan_unit(input int i);
        logic [31:0] t [CORDIC_MAX];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return signed'(t[i]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -48'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/plcj_cordic.sv @@
`default_nettype none
// pipelined sin/cos, one stage per iteration, plus fold and unfold stages
module plcj_cordic (
    input  wire logic                              i_clk,
    input  wire logic [15:0]                       i_angle,
    output logic signed [plcj_pkg::TRIG_W-1:0]     o_cos,
    output logic signed [plcj_pkg::TRIG_W-1:0]     o_sin
);
    import plcj_pkg::*;

    logic signed [TRIG_W-1:0] r_x [CORDIC_STAGES+1];
    logic signed [TRIG_W-1:0] r_y [CORDIC_STAGES+1];
    logic signed [33:0]       r_z [CORDIC_STAGES+1];
    logic                     r_flip [CORDIC_STAGES+1];
    logic                     n_flip;
    logic [15:0]              n_a;
    logic signed [TRIG_W-1:0] r_c, r_s;

    always_comb begin
        n_flip = (i_angle + 16'd16384) >= 16'd32768;
        n_a    = n_flip ? (i_angle ^ 16'h8000) : i_angle;
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_X0;
        r_y[0]    <= '0;
        r_z[0]    <= {{2{n_a[15]}}, n_a, 16'd0};
        r_flip[0] <= n_flip;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!r_z[g][33]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - 34'(atan_unit(g));
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + 34'(atan_unit(g));
            end
            r_flip[g+1] <= r_flip[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= r_flip[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
        r_s <= r_flip[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];
    end
    assign o_cos = r_c;
    assign o_sin = r_s;
endmodule
`default_nettype wire

@@ rtl/core/plcj_rotate.sv @@
`default_nettype none
// anchor rotation: products, then sum and round (two register stages)
module plcj_rotate (
    input  wire logic                              i_clk,
    input  wire logic signed [plcj_pkg::TRIG_W-1:0] i_cos,
    input  wire logic signed [plcj_pkg::TRIG_W-1:0] i_sin,
    input  wire logic signed [31:0]                i_ax,
    input  wire logic signed [31:0]                i_ay,
    output logic signed [33:0]                     o_rx,
    output logic signed [33:0]                     o_ry
);
    import plcj_pkg::*;

    logic signed [64:0] r_cx, r_sy, r_sx, r_cy;
    logic signed [66:0] n_rx, n_ry;
    logic signed [33:0] r_rx, r_ry;

    always_ff @(posedge i_clk) begin
        r_cx <= i_cos * i_ax;
        r_sy <= i_sin * i_ay;
        r_sx <= i_sin * i_ax;
        r_cy <= i_cos * i_ay;
    end

    always_comb begin
        n_rx = 67'(r_cx) - 67'(r_sy) + 67'sd536870912;
        n_ry = 67'(r_sx) + 67'(r_cy) + 67'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        r_rx <= 34'(n_rx >>> 30);
        r_ry <= 34'(n_ry >>> 30);
    end
    assign o_rx = r_rx;
    assign o_ry = r_ry;
endmodule
`default_nettype wire

@@ rtl/core/plcj_spring.sv @@
`default_nettype none
// spring force: magnitude, product, round and sign (three register stages)
module plcj_spring (
    input  wire logic                i_clk,
    input  wire logic signed [35:0]  i_gap,
    input  wire logic [31:0]         i_stiff,
    output logic signed [31:0]       o_force
);
    logic [35:0] r_mag;
    logic        r_neg0, r_neg1;
    logic [31:0] r_k;
    logic [51:0] r_hi;
    logic [47:0] r_lo;
    logic [52:0] n_p;
    logic [31:0] n_f;
    logic signed [31:0] r_f;

    always_ff @(posedge i_clk) begin
        r_mag  <= i_gap[35] ? 36'(-i_gap) : 36'(i_gap);
        r_neg0 <= i_gap[35];
        r_k    <= i_stiff;
        r_hi   <= 52'(r_k) * 52'(r_mag[35:16]);
        r_lo   <= 48'(r_k) * 48'(r_mag[15:0]);
        r_neg1 <= r_neg0;
    end

    always_comb begin
        n_p = 53'(r_hi) + 53'((r_lo + 48'h8000) >> 16);
        if (r_neg1) n_f = (n_p >= 53'h80000000) ? 32'h80000000 : -n_p[31:0];
        else        n_f = (n_p >= 53'h80000000) ? 32'h7FFFFFFF : n_p[31:0];
    end

    always_ff @(posedge i_clk) r_f <= signed'(n_f);
    assign o_force = r_f;
endmodule
`default_nettype wire

@@ rtl/core/planar_link_constraint_jacobian_unit.sv @@
`default_nettype none
// Pin-link constraint evaluator for a planar two-body joint. One query may be
// started every cycle (busy stays low); each gives exactly one result, strobed
// on o_done for one cycle once it has passed the unrolled CORDIC, the
// anchor-rotation multipliers and the spring multiplier. The receiver cannot
// stall the pipe, so results must be taken when strobed. Registers are APB
// writable; write them only when no query is in flight.
module planar_link_constraint_jacobian_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire plcj_pkg::t_in_item    i_item,
    output logic                       o_done,
    output plcj_pkg::t_out_item        o_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [4:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import plcj_pkg::*;
    `include "planar_link_constraint_jacobian_unit_assert.svh"

    localparam int LAT = PIPE_DEPTH;

    logic [7:0]  r_fi, r_si;
    logic [31:0] r_ax1, r_ay1, r_ax2, r_ay2, r_stiff, r_damp;
    logic        wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fi <= 8'd0; r_si <= 8'd1;
            r_ax1 <= '0; r_ay1 <= '0; r_ax2 <= '0; r_ay2 <= '0;
            r_stiff <= 32'd32768000; r_damp <= 32'd1310720;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_FIRST_INDEX:  r_fi    <= pwdata[7:0];
                REG_SECOND_INDEX: r_si    <= pwdata[7:0];
                REG_FIRST_AX:     r_ax1   <= pwdata;
                REG_FIRST_AY:     r_ay1   <= pwdata;
                REG_SECOND_AX:    r_ax2   <= pwdata;
                REG_SECOND_AY:    r_ay2   <= pwdata;
                REG_STIFFNESS:    r_stiff <= pwdata;
                REG_DAMPING:      r_damp  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_FIRST_INDEX:  prdata = {24'd0, r_fi};
            REG_SECOND_INDEX: prdata = {24'd0, r_si};
            REG_FIRST_AX:     prdata = r_ax1;
            REG_FIRST_AY:     prdata = r_ay1;
            REG_SECOND_AX:    prdata = r_ax2;
            REG_SECOND_AY:    prdata = r_ay2;
            REG_STIFFNESS:    prdata = r_stiff;
            REG_DAMPING:      prdata = r_damp;
        endcase
    end

    // decode at entry
    t_ctl n_ctl;
    logic is_first, is_second;
    always_comb begin
        is_first  = i_item.body_index[BODY_INDEX_BITS-1:0] == r_fi[BODY_INDEX_BITS-1:0];
        is_second = i_item.body_index[BODY_INDEX_BITS-1:0] == r_si[BODY_INDEX_BITS-1:0];
        n_ctl.hit    = is_first || is_second;
        n_ctl.second = !is_first;
        n_ctl.oax    = signed'(is_first ? r_ax1 : r_ax2);
        n_ctl.oay    = signed'(is_first ? r_ay1 : r_ay2);
        n_ctl.lax    = signed'(is_first ? r_ax2 : r_ax1);
        n_ctl.lay    = signed'(is_first ? r_ay2 : r_ay1);
        n_ctl.dx     = 33'(i_item.own_x) - 33'(i_item.other_x);
        n_ctl.dy     = 33'(i_item.own_y) - 33'(i_item.other_y);
        n_ctl.stiff  = r_stiff;
        n_ctl.damp   = r_damp;
    end

    logic r_v   [LAT+1];
    t_ctl r_ctl [LAT+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else          r_v[0] <= start && !busy;
        r_ctl[0] <= n_ctl;
    end
    for (genvar g = 0; g < LAT; g++) begin : g_pipe
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[g+1] <= 1'b0;
            else          r_v[g+1] <= r_v[g];
            r_ctl[g+1] <= r_ctl[g];
        end
    end

    // cordic input stage registers with ctl stage 0, so its outputs line up with ctl index TS
    logic signed [TRIG_W-1:0] oc, os, lc, ls;
    plcj_cordic u_cord_own (.i_clk(i_clk), .i_angle(i_item.own_angle),
        .o_cos(oc), .o_sin(os));
    plcj_cordic u_cord_lnk (.i_clk(i_clk), .i_angle(i_item.other_angle),
        .o_cos(lc), .o_sin(ls));

    localparam int TS = CORDIC_STAGES + 1;
    logic signed [33:0] rx, ry, lx, ly;
    plcj_rotate u_rot_own (.i_clk(i_clk), .i_cos(oc), .i_sin(os),
        .i_ax(r_ctl[TS].oax), .i_ay(r_ctl[TS].oay), .o_rx(rx), .o_ry(ry));
    plcj_rotate u_rot_lnk (.i_clk(i_clk), .i_cos(lc), .i_sin(ls),
        .i_ax(r_ctl[TS].lax), .i_ay(r_ctl[TS].lay), .o_rx(lx), .o_ry(ly));

    localparam int RS = TS + 2;
    logic signed [35:0] n_gx, n_gy;
    logic signed [35:0] r_gx, r_gy;
    logic signed [31:0] r_jx, r_jy, r_cx, r_cy;
    logic signed [31:0] r_jx2, r_jy2, r_cx2, r_cy2, r_jx3, r_jy3, r_cx3, r_cy3;
    logic signed [31:0] r_jx4, r_jy4, r_cx4, r_cy4;
    always_comb begin
        n_gx = 36'(r_ctl[RS].dx) + 36'(rx) - 36'(lx);
        n_gy = 36'(r_ctl[RS].dy) + 36'(ry) - 36'(ly);
    end
    always_ff @(posedge i_clk) begin
        r_gx <= r_ctl[RS].second ? -n_gx : n_gx;
        r_gy <= r_ctl[RS].second ? -n_gy : n_gy;
        r_jx <= sat32(r_ctl[RS].second ? 48'(ry) : -48'(ry));
        r_jy <= sat32(r_ctl[RS].second ? -48'(rx) : 48'(rx));
        r_cx <= sat32(r_ctl[RS].second ? 48'(rx) : -48'(rx));
        r_cy <= sat32(r_ctl[RS].second ? 48'(ry) : -48'(ry));
        r_jx2 <= r_jx; r_jy2 <= r_jy; r_cx2 <= r_cx; r_cy2 <= r_cy;
        r_jx3 <= r_jx2; r_jy3 <= r_jy2; r_cx3 <= r_cx2; r_cy3 <= r_cy2;
        r_jx4 <= r_jx3; r_jy4 <= r_jy3; r_cx4 <= r_cx3; r_cy4 <= r_cy3;
    end

    localparam int SS = RS + 1;
    logic signed [31:0] fx, fy;
    plcj_spring u_spr_x (.i_clk(i_clk), .i_gap(r_gx), .i_stiff(r_ctl[SS].stiff),
        .o_force(fx));
    plcj_spring u_spr_y (.i_clk(i_clk), .i_gap(r_gy), .i_stiff(r_ctl[SS].stiff),
        .o_force(fy));

    // spring has 3 stages: result aligned with ctl index SS+3 = LAT
    always_comb begin
        o_done = r_v[LAT];
        o_item = '0;
        if (r_ctl[LAT].hit) begin
            o_item.constraint_count = 2'd2;
            o_item.linear_sign      = r_ctl[LAT].second;
            o_item.jac_x_angle      = r_jx4;
            o_item.jac_y_angle      = r_jy4;
            o_item.curv_x_angle     = r_cx4;
            o_item.curv_y_angle     = r_cy4;
            o_item.spring_x         = fx;
            o_item.spring_y         = fy;
            o_item.damping_out      = r_ctl[LAT].damp;
        end
    end

    `PLCJ_ASSERT_NEXT(a_start_reaches_pipe, i_clk, i_rst_n, start, r_v[0])
    `PLCJ_ASSERT_IMP(a_count_matches_hit, i_clk, i_rst_n, o_done,
        (o_item.constraint_count == 2'd2) == r_ctl[LAT].hit)
    `PLCJ_ASSERT_IMP(a_miss_is_zero, i_clk, i_rst_n, o_done && !r_ctl[LAT].hit,
        o_item.damping_out == 32'd0 && o_item.spring_x == 32'sd0)
endmodule
`default_nettype wire
